@@ src/tksel_pkg.sv @@
// Package for the streaming top-K / bottom-K selector.
// Holds sizes, the (value, id) entry type and the pair-ranking function.
// No dependencies.
package tksel_pkg;

  localparam int KEEP_COUNT = 5;
  localparam int VALUE_W    = 32;
  localparam int ID_W       = 8;
  localparam int RANK_W     = 4;
  localparam int FILL_W     = $clog2(KEEP_COUNT + 1);
  localparam int IDX_W      = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;

  localparam logic signed [VALUE_W-1:0] MISSING_RESET = -32'sd65536;

  localparam logic LIST_HIGH = 1'b0;
  localparam logic LIST_LOW  = 1'b1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [ID_W-1:0]           id;
  } entry_t;

  typedef entry_t [KEEP_COUNT-1:0] table_t;

  // Snapshot control from the insert stage to the drain stage.
  typedef struct packed {
    logic              load;
    logic [FILL_W-1:0] hi_fill;
    logic [FILL_W-1:0] lo_fill;
  } dump_ctl_t;

  // True when a ranks strictly above b: larger value, then larger id.
  function automatic logic pair_gt(entry_t a, entry_t b);
    logic res;
    if (a.value != b.value) begin
      res = ($signed(a.value) > $signed(b.value));
    end else begin
      res = (a.id > b.id);
    end
    return res;
  endfunction

endpackage

@@ src/tksel_table.sv @@
// One sorted table of KEEP_COUNT entries with parallel compare-and-shift insertion.
// desc_i selects descending (largest kept) or ascending (smallest kept) order.
// Depends on tksel_pkg.
module tksel_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      desc_i,
  input  logic                      insert_i,
  input  logic                      clear_i,
  input  tksel_pkg::entry_t         entry_i,
  output tksel_pkg::table_t         tab_next_o,
  output logic [tksel_pkg::FILL_W-1:0] fill_next_o
);
  import tksel_pkg::*;

  table_t            tab_q, tab_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [KEEP_COUNT-1:0] vld, bet, mv, take;

  always_comb begin
    tab_d  = tab_q;
    fill_d = fill_q;
    mv     = '0;
    for (int i = 0; i < KEEP_COUNT; i++) begin
      vld[i] = (FILL_W'(i) < fill_q);
      bet[i] = desc_i ? pair_gt(entry_i, tab_q[i]) : pair_gt(tab_q[i], entry_i);
    end
    for (int i = 1; i < KEEP_COUNT; i++) begin
      mv[i] = vld[i-1] && bet[i-1];
    end
    for (int i = 0; i < KEEP_COUNT; i++) begin
      take[i] = ((vld[i] && bet[i]) || (FILL_W'(i) == fill_q)) && !mv[i];
    end
    if (insert_i) begin
      for (int i = 1; i < KEEP_COUNT; i++) begin
        if (mv[i]) begin
          tab_d[i] = tab_q[i-1];
        end
      end
      for (int i = 0; i < KEEP_COUNT; i++) begin
        if (take[i]) begin
          tab_d[i] = entry_i;
        end
      end
      if (fill_q < FILL_W'(KEEP_COUNT)) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
  end

  assign tab_next_o  = tab_d;
  assign fill_next_o = fill_d;

  always_ff @(posedge clk_i) begin
    tab_q <= tab_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= clear_i ? '0 : fill_d;
    end
  end

endmodule

@@ src/tksel_drain.sv @@
// Snapshot of both lists and the result register; sends high list then low list.
// Depends on tksel_pkg.
module tksel_drain (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tksel_pkg::dump_ctl_t        ctl_i,
  input  tksel_pkg::table_t           hi_i,
  input  tksel_pkg::table_t           lo_i,
  output logic                        ready_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tksel_pkg::ID_W-1:0]  result_id_o,
  output logic signed [tksel_pkg::VALUE_W-1:0] result_value_o,
  output logic                        list_select_o,
  output logic [tksel_pkg::RANK_W-1:0] rank_o,
  output logic                        last_result_o
);
  import tksel_pkg::*;

  table_t            hi_q, lo_q;
  logic [FILL_W-1:0] hi_fill_q, lo_fill_q;
  logic              active_q, sel_q;
  logic [IDX_W-1:0]  pos_q;
  logic              out_valid_q;
  entry_t            cur;
  logic              emit, more_in_list, final_one;
  logic [FILL_W:0]   pos_nx, cur_fill;

  assign ready_o = !active_q;
  assign emit    = active_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    cur          = (sel_q == LIST_HIGH) ? hi_q[pos_q] : lo_q[pos_q];
    cur_fill     = (sel_q == LIST_HIGH) ? (FILL_W+1)'(hi_fill_q) : (FILL_W+1)'(lo_fill_q);
    pos_nx       = (FILL_W+1)'(pos_q) + (FILL_W+1)'(1);
    more_in_list = (pos_nx < cur_fill);
    final_one    = !more_in_list && ((sel_q == LIST_LOW) || (lo_fill_q == '0));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load && !active_q) begin
      hi_q      <= hi_i;
      lo_q      <= lo_i;
      hi_fill_q <= ctl_i.hi_fill;
      lo_fill_q <= ctl_i.lo_fill;
    end
    if (emit) begin
      result_id_o    <= cur.id;
      result_value_o <= cur.value;
      list_select_o  <= sel_q;
      rank_o         <= RANK_W'(pos_q);
      last_result_o  <= final_one;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      sel_q       <= LIST_HIGH;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Result register: hold while stalled, drop once taken.
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (ctl_i.load && !active_q) begin
        pos_q <= '0;
        if (ctl_i.hi_fill != '0) begin
          active_q <= 1'b1;
          sel_q    <= LIST_HIGH;
        end else if (ctl_i.lo_fill != '0) begin
          active_q <= 1'b1;
          sel_q    <= LIST_LOW;
        end
      end else if (emit) begin
        if (more_in_list) begin
          pos_q <= pos_q + IDX_W'(1);
        end else if (final_one) begin
          active_q <= 1'b0;
        end else begin
          sel_q <= LIST_LOW;
          pos_q <= '0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/top_k_bottom_k_selector.sv @@
// Streaming top-K / bottom-K selector: input register, two sorted tables, drain.
// Order: input register, then table update; on a last item the drain snapshots the
// tables, then the first result enters the result register. Throughput: one item
// per cycle unless a last item waits in the input register for the drain. A last
// item sends up to 2*KEEP_COUNT results, one per cycle unless the output stalls.
// Reset clears fill counts, valid flags and sets missing_code to -1.0 (Q16.16).
module top_k_bottom_k_selector (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_wr_en_i,
  input  logic signed [tksel_pkg::VALUE_W-1:0]  cfg_wr_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [tksel_pkg::VALUE_W-1:0]  metric_value_i,
  input  logic [tksel_pkg::ID_W-1:0]            item_id_i,
  input  logic                                  eligible_i,
  input  logic                                  last_item_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [tksel_pkg::ID_W-1:0]            result_id_o,
  output logic signed [tksel_pkg::VALUE_W-1:0]  result_value_o,
  output logic                                  list_select_o,
  output logic [tksel_pkg::RANK_W-1:0]          rank_o,
  output logic                                  last_result_o
);
  import tksel_pkg::*;

  // Configuration: missing-value code.
  logic signed [VALUE_W-1:0] missing_q;

  // Input register.
  logic   in_valid_q, elig_q, last_q;
  entry_t item_q;

  logic   accept, advance, insert, clear, drain_ready;
  table_t hi_next, lo_next;
  logic [FILL_W-1:0] hi_fill_next, lo_fill_next;
  dump_ctl_t ctl;

  // A non-last item always advances; a last item waits until the drain is free.
  assign advance    = !last_q || drain_ready;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign insert = in_valid_q && advance && elig_q && (item_q.value != missing_q);
  assign clear  = in_valid_q && advance && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      missing_q  <= MISSING_RESET;
      in_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        missing_q <= cfg_wr_data_i;
      end
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
    end
  end

  // Payload of the input register: capture on transfer only.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.value <= metric_value_i;
      item_q.id    <= item_id_i;
      elig_q       <= eligible_i;
      last_q       <= last_item_i;
    end
  end

  // Largest entries, kept descending.
  tksel_table u_hi (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (1'b1),
    .insert_i    (insert),
    .clear_i     (clear),
    .entry_i     (item_q),
    .tab_next_o  (hi_next),
    .fill_next_o (hi_fill_next)
  );

  // Smallest entries, kept ascending.
  tksel_table u_lo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (1'b0),
    .insert_i    (insert),
    .clear_i     (clear),
    .entry_i     (item_q),
    .tab_next_o  (lo_next),
    .fill_next_o (lo_fill_next)
  );

  // The snapshot includes the last item's own insertion; the tables clear behind it.
  always_comb begin
    ctl.load    = clear;
    ctl.hi_fill = hi_fill_next;
    ctl.lo_fill = lo_fill_next;
  end

  tksel_drain u_drain (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .hi_i           (hi_next),
    .lo_i           (lo_next),
    .ready_o        (drain_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_id_o    (result_id_o),
    .result_value_o (result_value_o),
    .list_select_o  (list_select_o),
    .rank_o         (rank_o),
    .last_result_o  (last_result_o)
  );

endmodule
